// ===== sv/rss_pkg.sv =====
// Package: shared constants, opcodes and cell interface structs for the station scheduler.
`default_nettype none
package rss_pkg;

  localparam int MaxPerClass = 10;
  localparam int NumStations = 3 * MaxPerClass;
  localparam int NumRegs     = 32;
  localparam int TagW        = 5;
  localparam int LatW        = 6;
  localparam int CntW        = 4;
  localparam int ValW        = 16;
  localparam int RegIdxW     = 5;

  // Operation codes
  typedef enum logic [2:0] {
    FN_LOAD = 3'd0,
    FN_ADD  = 3'd1,
    FN_SUB  = 3'd2,
    FN_MUL  = 3'd3,
    FN_DIV  = 3'd4
  } func_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_LOAD_ST  = 3'd0,
    CFG_ADD_ST   = 3'd1,
    CFG_MUL_ST   = 3'd2,
    CFG_LOAD_LAT = 3'd3,
    CFG_ADD_LAT  = 3'd4,
    CFG_MUL_LAT  = 3'd5,
    CFG_DIV_LAT  = 3'd6,
    CFG_BCAST    = 3'd7
  } cfg_idx_t;

  // Per-cycle control into one station cell
  typedef struct packed {
    logic            step;
    logic            issue;
    logic            in_range;
    logic [TagW-1:0] tag_a;
    logic [TagW-1:0] tag_b;
    logic [LatW-1:0] latency;
    logic            bcast_valid;
    logic [TagW-1:0] bcast_tag;
  } cell_ctl_t;

  // Status out of one station cell
  typedef struct packed {
    logic take;
    logic grant;
    logic ended;
  } cell_stat_t;

endpackage
`default_nettype wire

// ===== sv/rss_station.sv =====
// One reservation station cell: issue/write priority chains, countdown and tag snooping.
`default_nettype none
module rss_station (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire rss_pkg::cell_ctl_t   ctl,
  input  wire logic                 free_in,
  output logic                      free_out,
  input  wire logic                 pend_in,
  output logic                      pend_out,
  output rss_pkg::cell_stat_t       stat
);

  logic                     busy_r, busy_nxt;
  logic                     fin_r, fin_nxt;
  logic [rss_pkg::LatW-1:0] cnt_r, cnt_nxt;
  logic [rss_pkg::TagW-1:0] tag_a_r, tag_a_nxt;
  logic [rss_pkg::TagW-1:0] tag_b_r, tag_b_nxt;

  logic                     avail, take, cand, grant, run, ended;
  logic [rss_pkg::LatW-1:0] cnt_dec;
  logic [rss_pkg::TagW-1:0] ta, tb;

  // Issue chain: first free station in the class range takes the item
  assign avail    = ctl.in_range & ~busy_r;
  assign take     = ctl.issue & avail & ~free_in;
  assign free_out = free_in | avail;

  // Write chain: lowest station finished in an earlier cycle wins the bus
  assign cand     = busy_r & fin_r;
  assign grant    = cand & ~pend_in;
  assign pend_out = pend_in | cand;

  // Countdown once both operands are present
  assign run     = busy_r & ~fin_r & (tag_a_r == '0) & (tag_b_r == '0);
  assign cnt_dec = cnt_r - rss_pkg::LatW'(1);
  assign ended   = run & (cnt_dec == '0);

  assign ta = take ? ctl.tag_a : tag_a_r;
  assign tb = take ? ctl.tag_b : tag_b_r;

  assign stat.take  = take;
  assign stat.grant = grant;
  assign stat.ended = ended;

  // Next state
  always_comb begin
    busy_nxt  = busy_r;
    fin_nxt   = fin_r;
    cnt_nxt   = cnt_r;
    tag_a_nxt = tag_a_r;
    tag_b_nxt = tag_b_r;
    if (grant) begin
      busy_nxt  = 1'b0;
      fin_nxt   = 1'b0;
      cnt_nxt   = '0;
      tag_a_nxt = '0;
      tag_b_nxt = '0;
    end else begin
      if (take) begin
        busy_nxt = 1'b1;
        fin_nxt  = 1'b0;
        cnt_nxt  = ctl.latency;
      end else if (run) begin
        cnt_nxt = cnt_dec;
        fin_nxt = ended;
      end
      // snoop the bus for operands
      tag_a_nxt = (ctl.bcast_valid && ta == ctl.bcast_tag) ? '0 : ta;
      tag_b_nxt = (ctl.bcast_valid && tb == ctl.bcast_tag) ? '0 : tb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      fin_r   <= 1'b0;
      cnt_r   <= '0;
      tag_a_r <= '0;
      tag_b_r <= '0;
    end else if (ctl.step) begin
      busy_r  <= busy_nxt;
      fin_r   <= fin_nxt;
      cnt_r   <= cnt_nxt;
      tag_a_r <= tag_a_nxt;
      tag_b_r <= tag_b_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/reservation_station_scheduler_core.sv =====
// Top level: Tomasulo station scheduler, a row of station cells plus register tag file.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/in_tready | tuser: instr_valid; tdata: func,dest,src_a,src_b
//  out_    | out | out_tvalid/out_tready | tdata: issue, exec, write-back, busy count
//  cfg_    | in  | cfg_we              | cfg_addr index, cfg_wdata value
//
// One item is one scheduler step; its result is registered in the output
// register. The issue and write priority chains run combinationally through
// all 30 cells. A new item is taken while a result waits, as long as the
// output register is empty or being drained.
// Synchronous active-low reset clears all stations and tags; config to defaults.
`default_nettype none
module reservation_station_scheduler_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // func[2:0], dest_reg[7:3], src_a_reg[12:8], src_b_reg[17:13]
  input  wire logic        in_tuser,   // instr_valid
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // issued[0], issue_station[5:1], exec_end_mask[35:6],
                                       // wb_valid[36], wb_station[41:37], wb_value[57:42],
                                       // busy_count[62:58]
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  localparam int NS = rss_pkg::NumStations;
  localparam int TW = rss_pkg::TagW;

  // Configuration registers
  logic [rss_pkg::CntW-1:0] n_ld_r, n_add_r, n_mul_r;
  logic [rss_pkg::LatW-1:0] lat_ld_r, lat_add_r, lat_mul_r, lat_div_r;
  logic [rss_pkg::ValW-1:0] bval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_ld_r    <= 4'd3;
      n_add_r   <= 4'd3;
      n_mul_r   <= 4'd2;
      lat_ld_r  <= 6'd2;
      lat_add_r <= 6'd2;
      lat_mul_r <= 6'd10;
      lat_div_r <= 6'd40;
      bval_r    <= 16'd99;
    end else if (cfg_we) begin
      case (rss_pkg::cfg_idx_t'(cfg_addr))
        rss_pkg::CFG_LOAD_ST:  n_ld_r    <= cfg_wdata[3:0];
        rss_pkg::CFG_ADD_ST:   n_add_r   <= cfg_wdata[3:0];
        rss_pkg::CFG_MUL_ST:   n_mul_r   <= cfg_wdata[3:0];
        rss_pkg::CFG_LOAD_LAT: lat_ld_r  <= cfg_wdata[5:0];
        rss_pkg::CFG_ADD_LAT:  lat_add_r <= cfg_wdata[5:0];
        rss_pkg::CFG_MUL_LAT:  lat_mul_r <= cfg_wdata[5:0];
        rss_pkg::CFG_DIV_LAT:  lat_div_r <= cfg_wdata[5:0];
        rss_pkg::CFG_BCAST:    bval_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input fields
  logic        step;
  logic [2:0]  func;
  logic [4:0]  dest, src_a, src_b;
  logic        out_tvalid_r;
  logic [63:0] out_tdata_r;

  assign in_tready = ~out_tvalid_r | out_tready;
  assign step      = in_tvalid & in_tready;
  assign func      = in_tdata[2:0];
  assign dest      = in_tdata[7:3];
  assign src_a     = in_tdata[12:8];
  assign src_b     = in_tdata[17:13];

  // Class range and latency of the offered op
  logic [4:0] c_ld, c_add, c_mul, rng_lo, rng_hi;
  logic [rss_pkg::LatW-1:0] lat;
  logic issue;

  assign c_ld  = (n_ld_r  > 4'd10) ? 5'd10 : {1'b0, n_ld_r};
  assign c_add = (n_add_r > 4'd10) ? 5'd10 : {1'b0, n_add_r};
  assign c_mul = (n_mul_r > 4'd10) ? 5'd10 : {1'b0, n_mul_r};

  always_comb begin
    issue  = in_tuser;
    rng_lo = 5'd0;
    rng_hi = 5'd0;
    lat    = lat_ld_r;
    case (rss_pkg::func_t'(func))
      rss_pkg::FN_LOAD: begin
        rng_hi = c_ld;
      end
      rss_pkg::FN_ADD, rss_pkg::FN_SUB: begin
        rng_lo = c_ld;
        rng_hi = c_ld + c_add;
        lat    = lat_add_r;
      end
      rss_pkg::FN_MUL: begin
        rng_lo = c_ld + c_add;
        rng_hi = c_ld + c_add + c_mul;
        lat    = lat_mul_r;
      end
      rss_pkg::FN_DIV: begin
        rng_lo = c_ld + c_add;
        rng_hi = c_ld + c_add + c_mul;
        lat    = lat_div_r;
      end
      default: issue = 1'b0;
    endcase
  end

  // Register tag file: source capture
  logic [TW-1:0] reg_tag_r [rss_pkg::NumRegs];
  logic [TW-1:0] cap_a, cap_b;
  logic          is_load;

  assign is_load = (func == rss_pkg::FN_LOAD);
  assign cap_a   = is_load ? '0 : reg_tag_r[src_a];
  assign cap_b   = is_load ? '0 : reg_tag_r[src_b];

  // Station row
  rss_pkg::cell_ctl_t  ctl  [NS];
  rss_pkg::cell_stat_t stat [NS];
  logic [NS:0]   free_ch, pend_ch;
  logic [NS-1:0] take_vec, grant_vec, end_vec;
  logic [4:0]    iss_st, wb_st;
  logic          issued, wb_valid;
  logic [TW-1:0] new_tag, wb_tag;

  assign free_ch[0] = 1'b0;
  assign pend_ch[0] = 1'b0;

  for (genvar i = 0; i < NS; i++) begin : g_st
    always_comb begin
      ctl[i].step        = step;
      ctl[i].issue       = issue;
      ctl[i].in_range    = (5'(i) >= rng_lo) && (5'(i) < rng_hi);
      ctl[i].tag_a       = cap_a;
      ctl[i].tag_b       = cap_b;
      ctl[i].latency     = lat;
      ctl[i].bcast_valid = wb_valid;
      ctl[i].bcast_tag   = wb_tag;
    end
    rss_station u_st (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl[i]),
      .free_in  (free_ch[i]),
      .free_out (free_ch[i+1]),
      .pend_in  (pend_ch[i]),
      .pend_out (pend_ch[i+1]),
      .stat     (stat[i])
    );
    assign take_vec[i]  = stat[i].take;
    assign grant_vec[i] = stat[i].grant;
    assign end_vec[i]   = stat[i].ended;
  end

  // One-hot to index
  always_comb begin
    iss_st = '0;
    wb_st  = '0;
    for (int k = 0; k < NS; k++) begin
      if (take_vec[k])  iss_st = iss_st | 5'(k);
      if (grant_vec[k]) wb_st  = wb_st  | 5'(k);
    end
  end

  assign issued   = |take_vec;
  assign wb_valid = |grant_vec;
  assign new_tag  = iss_st + TW'(1);
  assign wb_tag   = wb_st + TW'(1);

  // Rename destination, then clear tags of the writing station
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < rss_pkg::NumRegs; r++) reg_tag_r[r] <= '0;
    end else if (step) begin
      for (int r = 0; r < rss_pkg::NumRegs; r++) begin
        if (issued && dest == 5'(r)) reg_tag_r[r] <= new_tag;
        else if (wb_valid && reg_tag_r[r] == wb_tag) reg_tag_r[r] <= '0;
      end
    end
  end

  // Busy station count
  logic [4:0] busy_cnt_r, busy_cnt_nxt;

  assign busy_cnt_nxt = busy_cnt_r + 5'(issued) - 5'(wb_valid);

  always_ff @(posedge clk) begin
    if (!rst_n) busy_cnt_r <= '0;
    else if (step) busy_cnt_r <= busy_cnt_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (step) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_tdata_r <= {1'b0, busy_cnt_nxt, (wb_valid ? bval_r : 16'd0), wb_st, wb_valid,
                      end_vec, iss_st, issued};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Checks
  a_grant_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(grant_vec)) else $error("more than one station writes");
  a_take_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(take_vec)) else $error("more than one station takes the item");
  a_busy_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_cnt_r <= 5'(NS)) else $error("busy count out of range");
  a_no_take_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (take_vec & grant_vec) == '0) else $error("station issued and written at once");

endmodule
`default_nettype wire
